### sv/plf_pkg.sv
package plf_pkg;

   // component and color widths
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned COLOR_W  = 3 * CHAN_W;
   localparam int unsigned INDEX_W  = 8;

   // depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // blend weight that selects the target color alone
   localparam logic [CHAN_W-1:0] LEVEL_FULL = 8'hFF;

   // fixed ega component levels
   localparam logic [CHAN_W-1:0] EGA_OFF = 8'h00;
   localparam logic [CHAN_W-1:0] EGA_LOW = 8'h55;
   localparam logic [CHAN_W-1:0] EGA_MID = 8'hAA;
   localparam logic [CHAN_W-1:0] EGA_TOP = 8'hFF;

   // request action codes
   typedef enum logic [1:0] {
      ACT_VGA  = 2'd0,
      ACT_EGA  = 2'd1,
      ACT_FADE = 2'd2,
      ACT_READ = 2'd3
   } action_type;

   // work kinds handed to the back end
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FADE  = 2'd1,
      OP_READ  = 2'd2
   } op_kind_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_READ = 2'd1,
      BK_MULT = 2'd2,
      BK_DONE = 2'd3
   } back_state_type;

   // one classified item
   typedef struct packed {
      op_kind_type          kind;
      logic [INDEX_W-1:0]   index;
      logic                 idx_ok;
      logic [INDEX_W-1:0]   target;
      logic                 tgt_ok;
      logic [CHAN_W-1:0]    level;
      logic [COLOR_W-1:0]   color;
      logic                 last;
   } op_type;

   // the sixteen fixed ega colors, red in the top byte
   function automatic logic [COLOR_W-1:0] ega_color(input logic [3:0] code);
      logic [COLOR_W-1:0] rgb;
      case (code)
         4'd0:    rgb = {EGA_OFF, EGA_OFF, EGA_OFF};
         4'd1:    rgb = {EGA_OFF, EGA_OFF, EGA_MID};
         4'd2:    rgb = {EGA_OFF, EGA_MID, EGA_OFF};
         4'd3:    rgb = {EGA_OFF, EGA_MID, EGA_MID};
         4'd4:    rgb = {EGA_MID, EGA_OFF, EGA_OFF};
         4'd5:    rgb = {EGA_MID, EGA_OFF, EGA_MID};
         4'd6:    rgb = {EGA_MID, EGA_LOW, EGA_OFF};
         4'd7:    rgb = {EGA_MID, EGA_MID, EGA_MID};
         4'd8:    rgb = {EGA_LOW, EGA_LOW, EGA_LOW};
         4'd9:    rgb = {EGA_LOW, EGA_LOW, EGA_TOP};
         4'd10:   rgb = {EGA_LOW, EGA_TOP, EGA_LOW};
         4'd11:   rgb = {EGA_LOW, EGA_TOP, EGA_TOP};
         4'd12:   rgb = {EGA_TOP, EGA_LOW, EGA_LOW};
         4'd13:   rgb = {EGA_TOP, EGA_LOW, EGA_TOP};
         4'd14:   rgb = {EGA_TOP, EGA_TOP, EGA_LOW};
         4'd15:   rgb = {EGA_TOP, EGA_TOP, EGA_TOP};
         default: rgb = {EGA_OFF, EGA_OFF, EGA_OFF};
      endcase
      return rgb;
   endfunction

endpackage

### sv/plf_ram.sv
module plf_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### sv/plf_front.sv
module plf_front
   import plf_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic [1:0]         req_action,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [5:0]         req_red_six,
   input  logic [5:0]         req_green_six,
   input  logic [5:0]         req_blue_six,
   input  logic [3:0]         req_ega_code,
   input  logic [INDEX_W-1:0] req_target_index,
   input  logic [CHAN_W-1:0]  req_fade_level,
   input  logic               req_last_of_range,
   output op_type             op
);

   action_type act;

   assign act = action_type'(req_action);

   // classify the item and work out the color a write stores
   always_comb begin
      op        = '0;
      op.index  = req_entry_index;
      op.idx_ok = {1'b0, req_entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);
      op.target = req_target_index;
      op.tgt_ok = {1'b0, req_target_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);
      op.level  = req_fade_level;
      op.last   = req_last_of_range;
      case (act)
         ACT_VGA: begin
            op.kind  = OP_WRITE;
            op.color = {req_red_six, 2'b00, req_green_six, 2'b00, req_blue_six, 2'b00};
         end
         ACT_EGA: begin
            op.kind  = OP_WRITE;
            op.color = ega_color(req_ega_code);
         end
         ACT_FADE: begin
            op.kind = OP_FADE;
         end
         default: begin
            op.kind = OP_READ;
         end
      endcase
   end

endmodule

### sv/plf_queue.sv
module plf_queue
   import plf_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   has_room,
   input  logic   pop,
   output logic   has_item,
   output op_type head_op
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign has_room = count_ff != CNT_W'(QUEUE_DEPTH);
   assign has_item = count_ff != '0;
   assign head_op  = slot_ff[rd_ptr_ff];

   // occupancy follows push and pop
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // pointers wrap at the queue depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // item slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### sv/plf_back.sv
module plf_back
   import plf_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_has_item,
   input  op_type                             q_head_op,
   output logic                               q_pop,
   output logic                               ram_we,
   output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
   output logic [COLOR_W-1:0]                 ram_wdata,
   output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr_a,
   output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr_b,
   input  logic [COLOR_W-1:0]                 ram_rdata_a,
   input  logic [COLOR_W-1:0]                 ram_rdata_b,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [INDEX_W-1:0]                 rsp_out_index,
   output logic [CHAN_W-1:0]                  rsp_out_red,
   output logic [CHAN_W-1:0]                  rsp_out_green,
   output logic [CHAN_W-1:0]                  rsp_out_blue,
   output logic                               rsp_run_done
);

   localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam int unsigned PROD_W = 2 * CHAN_W;

   back_state_type           state_ff;
   back_state_type           state_in;
   op_type                   op_ff;
   logic [PALETTE_ENTRIES-1:0] written_ff;
   logic                     base_ok_ff;
   logic                     tgt_ok_ff;
   logic [COLOR_W-1:0]       color_ff;
   logic [PROD_W-1:0]        prod_t_ff [3];
   logic [PROD_W-1:0]        prod_b_ff [3];
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [INDEX_W-1:0]       rsp_index_ff;
   logic [COLOR_W-1:0]       rsp_color_ff;
   logic                     rsp_last_ff;
   logic                     load_rsp;
   logic [COLOR_W-1:0]       base_rgb;
   logic [COLOR_W-1:0]       tgt_rgb;
   logic [COLOR_W-1:0]       blend_rgb;
   logic [CHAN_W-1:0]        inv_level;
   logic [PROD_W:0]          blend_sum [3];
   logic [PROD_W:0]          blend_quo [3];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_has_item) begin
               state_in = (q_head_op.kind == OP_WRITE) ? BK_DONE : BK_READ;
            end
         end
         BK_READ: state_in = (op_ff.kind == OP_FADE) ? BK_MULT : BK_DONE;
         BK_MULT: state_in = BK_DONE;
         BK_DONE: begin
            if (load_rsp) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop       = (state_ff == BK_IDLE) && q_has_item;
      ram_we      = q_pop && (q_head_op.kind == OP_WRITE) && q_head_op.idx_ok;
      ram_waddr   = q_head_op.index[ADDR_W-1:0];
      ram_wdata   = q_head_op.color;
      ram_raddr_a = q_head_op.index[ADDR_W-1:0];
      ram_raddr_b = q_head_op.target[ADDR_W-1:0];
      load_rsp    = (state_ff == BK_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // entries never written read as black
   assign base_rgb  = base_ok_ff ? ram_rdata_a : '0;
   assign tgt_rgb   = tgt_ok_ff ? ram_rdata_b : '0;
   assign inv_level = LEVEL_FULL - op_ff.level;

   // divide by 255: floor(x / 255) = (x + (x >> 8) + 1) >> 8 for x up to 255 * 255
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blend_sum[c] = {1'b0, prod_t_ff[c]} + {1'b0, prod_b_ff[c]};
         blend_quo[c] = blend_sum[c] + (PROD_W + 1)'(blend_sum[c][PROD_W-1:CHAN_W])
                        + (PROD_W + 1)'(1);
         blend_rgb[c*CHAN_W +: CHAN_W] = blend_quo[c][PROD_W-1:CHAN_W];
      end
   end

   // response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            written_ff[q_head_op.index[ADDR_W-1:0]] <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff      <= q_head_op;
         color_ff   <= q_head_op.color;
         base_ok_ff <= q_head_op.idx_ok && written_ff[q_head_op.index[ADDR_W-1:0]];
         tgt_ok_ff  <= q_head_op.tgt_ok && written_ff[q_head_op.target[ADDR_W-1:0]];
      end
      if (state_ff == BK_READ) begin
         if (op_ff.kind == OP_READ) begin
            color_ff <= base_rgb;
         end
         for (int c = 0; c < 3; c++) begin
            prod_t_ff[c] <= {{CHAN_W{1'b0}}, tgt_rgb[c*CHAN_W +: CHAN_W]}
                            * {{CHAN_W{1'b0}}, op_ff.level};
            prod_b_ff[c] <= {{CHAN_W{1'b0}}, base_rgb[c*CHAN_W +: CHAN_W]}
                            * {{CHAN_W{1'b0}}, inv_level};
         end
      end
      if (state_ff == BK_MULT) begin
         color_ff <= blend_rgb;
      end
      if (load_rsp) begin
         rsp_index_ff <= op_ff.index;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= op_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_red   = rsp_color_ff[2*CHAN_W +: CHAN_W];
   assign rsp_out_green = rsp_color_ff[CHAN_W +: CHAN_W];
   assign rsp_out_blue  = rsp_color_ff[0 +: CHAN_W];
   assign rsp_run_done  = rsp_last_ff;

endmodule

### sv/palette_load_and_fade_unit.sv
// the back-end sequencer takes one item at a time; a write goes from idle to done, a read
// passes through the read state and a fade through the read and multiply states
// (memory read, multiply stage, divide-by-255 stage)
// a two-item queue lets the input keep accepting while the back end works
// reset is synchronous; per-entry written flags clear at once so the palette reads black
// with no clearing pass
module palette_load_and_fade_unit
   import plf_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [5:0]         req_red_six,
   input  logic [5:0]         req_green_six,
   input  logic [5:0]         req_blue_six,
   input  logic [3:0]         req_ega_code,
   input  logic [INDEX_W-1:0] req_target_index,
   input  logic [CHAN_W-1:0]  req_fade_level,
   input  logic               req_last_of_range,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_out_index,
   output logic [CHAN_W-1:0]  rsp_out_red,
   output logic [CHAN_W-1:0]  rsp_out_green,
   output logic [CHAN_W-1:0]  rsp_out_blue,
   output logic               rsp_run_done
);

   localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

   op_type             front_op;
   op_type             head_op;
   logic               q_has_item;
   logic               q_pop;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [COLOR_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr_a;
   logic [ADDR_W-1:0]  ram_raddr_b;
   logic [COLOR_W-1:0] ram_rdata_a;
   logic [COLOR_W-1:0] ram_rdata_b;

   // classify incoming items
   plf_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_red_six       (req_red_six),
      .req_green_six     (req_green_six),
      .req_blue_six      (req_blue_six),
      .req_ega_code      (req_ega_code),
      .req_target_index  (req_target_index),
      .req_fade_level    (req_fade_level),
      .req_last_of_range (req_last_of_range),
      .op                (front_op)
   );

   // queue between front and back
   plf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid && req_ready),
      .push_op  (front_op),
      .has_room (req_ready),
      .pop      (q_pop),
      .has_item (q_has_item),
      .head_op  (head_op)
   );

   // base palette store
   plf_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   // store, read and blend
   plf_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_has_item    (q_has_item),
      .q_head_op     (head_op),
      .q_pop         (q_pop),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr_a   (ram_raddr_a),
      .ram_raddr_b   (ram_raddr_b),
      .ram_rdata_a   (ram_rdata_a),
      .ram_rdata_b   (ram_rdata_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_index (rsp_out_index),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_run_done  (rsp_run_done)
   );

endmodule

### sv/plf_checker.sv
module plf_checker
   import plf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_out_index,
   input logic [CHAN_W-1:0]  rsp_out_red,
   input logic [CHAN_W-1:0]  rsp_out_green,
   input logic [CHAN_W-1:0]  rsp_out_blue,
   input logic               rsp_run_done
);

   // queue slots, one item in the back end and one in the response register
   localparam int unsigned MAX_HELD = QUEUE_DEPTH + 2;
   localparam int unsigned HELD_W   = $clog2(MAX_HELD + 1);

   logic [HELD_W-1:0] held_ff;
   logic              req_fire;
   logic              rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // items accepted and not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         held_ff <= held_ff + HELD_W'(1);
      end else if (rsp_fire && !req_fire) begin
         held_ff <= held_ff - HELD_W'(1);
      end
   end

   // a stalled response holds its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
         && $stable(rsp_out_red) && $stable(rsp_out_green)
         && $stable(rsp_out_blue) && $stable(rsp_run_done))
      else $error("response changed while stalled");

   // no response without an item taken in
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> held_ff != '0)
      else $error("response with no item outstanding");

   // an empty block takes input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      held_ff == '0 |-> req_ready)
      else $error("input stalled while block is empty");

   // a full block stops taking input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      held_ff == HELD_W'(MAX_HELD) |-> !req_ready)
      else $error("input accepted beyond capacity");

endmodule

bind palette_load_and_fade_unit plf_checker u_plf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_index (rsp_out_index),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_run_done  (rsp_run_done)
);
